/* rtl/assert_macros.svh */
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/xcfd_pkg.sv */
// ----------------------------------------------------------------------------
// xcfd_pkg
// Types and constants for the xor checked frame deframer.
// ----------------------------------------------------------------------------
package xcfd_pkg;

	localparam logic [7:0] FRAME_DELIM    = 8'h02;
	localparam logic [9:0] FRAME_OVERHEAD = 10'd5;
	localparam logic [9:0] HDR_LEN        = 10'd4;
	localparam logic [8:0] POS_MAX        = 9'd511;
	localparam logic [7:0] MAX_PAYLOAD_RST = 8'd255;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_SHORT  = 3'd1;
	localparam logic [2:0] ST_DELIM  = 3'd2;
	localparam logic [2:0] ST_OVER   = 3'd3;
	localparam logic [2:0] ST_LENGTH = 3'd4;
	localparam logic [2:0] ST_CHECK  = 3'd5;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] payload_byte;
		logic [7:0] polling_address;
		logic [7:0] command;
		logic [7:0] payload_length;
		logic [2:0] status;
	} res_t;

endpackage

/* rtl/xcfd_parse.sv */
// ----------------------------------------------------------------------------
// xcfd_parse
// Frame state (position, running xor, header bytes) and the per-byte decode.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xcfd_parse (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       byte_in,
	input  logic             last_in,
	input  logic [7:0]       max_payload,
	output logic             res_fire,
	output xcfd_pkg::res_t   res
);

	logic [8:0] pos_q;
	logic [7:0] xor_q;
	logic [7:0] addr_q;
	logic [7:0] cmd_q;
	logic [7:0] count_q;
	logic       delim_q;

	logic [7:0] addr_n;
	logic [7:0] cmd_n;
	logic [7:0] count_n;
	logic       delim_n;
	logic [7:0] xor_n;
	logic [9:0] pos_w;
	logic [9:0] total;
	logic       hdr_ok;
	logic       in_payload;
	logic [2:0] st;

	// header capture with this byte folded in
	always_comb begin
		addr_n  = addr_q;
		cmd_n   = cmd_q;
		count_n = count_q;
		delim_n = delim_q;
		unique case (pos_q)
			9'd0: delim_n = (byte_in == xcfd_pkg::FRAME_DELIM);
			9'd1: addr_n  = byte_in;
			9'd2: cmd_n   = byte_in;
			9'd3: count_n = byte_in;
			default: ;
		endcase
	end

	assign xor_n      = xor_q ^ byte_in;
	assign pos_w      = {1'b0, pos_q};
	assign total      = pos_w + 10'd1;
	assign hdr_ok     = delim_n && (count_n <= max_payload);
	assign in_payload = (pos_w >= xcfd_pkg::HDR_LEN) &&
		(pos_w < ({2'b00, count_n} + xcfd_pkg::HDR_LEN));

	always_comb begin
		priority if (total < xcfd_pkg::FRAME_OVERHEAD) begin
			st = xcfd_pkg::ST_SHORT;
		end else if (!delim_n) begin
			st = xcfd_pkg::ST_DELIM;
		end else if (count_n > max_payload) begin
			st = xcfd_pkg::ST_OVER;
		end else if (total != ({2'b00, count_n} + xcfd_pkg::FRAME_OVERHEAD)) begin
			st = xcfd_pkg::ST_LENGTH;
		end else if (xor_n != 8'd0) begin
			st = xcfd_pkg::ST_CHECK;
		end else begin
			st = xcfd_pkg::ST_OK;
		end
	end

	assign res_fire = step && (last_in || (hdr_ok && in_payload));

	always_comb begin
		res.polling_address = addr_n;
		res.command         = cmd_n;
		res.payload_length  = count_n;
		if (last_in) begin
			res.kind         = xcfd_pkg::KIND_STATUS;
			res.payload_byte = 8'd0;
			res.status       = st;
		end else begin
			res.kind         = xcfd_pkg::KIND_PAYLOAD;
			res.payload_byte = byte_in;
			res.status       = xcfd_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			xor_q   <= '0;
			addr_q  <= '0;
			cmd_q   <= '0;
			count_q <= '0;
			delim_q <= 1'b0;
		end else if (step) begin
			if (last_in) begin
				// frame done, start clean
				pos_q   <= '0;
				xor_q   <= '0;
				addr_q  <= '0;
				cmd_q   <= '0;
				count_q <= '0;
				delim_q <= 1'b0;
			end else begin
				if (pos_q != xcfd_pkg::POS_MAX) begin
					pos_q <= pos_q + 9'd1;
				end
				xor_q   <= xor_n;
				addr_q  <= addr_n;
				cmd_q   <= cmd_n;
				count_q <= count_n;
				delim_q <= delim_n;
			end
		end
	end

	`ASSERT_NEXT(a_clear_after_last, clk, arst_n, step && last_in,
		pos_q == 9'd0 && xor_q == 8'd0 && !delim_q, "frame state not cleared after last byte")
	`ASSERT_IMPL(a_payload_needs_delim, clk, arst_n,
		res_fire && res.kind == xcfd_pkg::KIND_PAYLOAD,
		delim_q && pos_q >= 9'd4, "payload byte sent without a valid header")
	`ASSERT_IMPL(a_fire_needs_step, clk, arst_n, res_fire, step,
		"result produced without a byte")

endmodule

/* rtl/xcfd_out.sv */
// ----------------------------------------------------------------------------
// xcfd_out
// Result register with valid/stall toward the receiver.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xcfd_out (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  xcfd_pkg::res_t   d,
	input  logic             stall,
	output logic             room,
	output logic             valid,
	output xcfd_pkg::res_t   q
);

	logic           valid_q;
	xcfd_pkg::res_t data_q;

	assign room  = !valid_q || !stall;
	assign valid = valid_q;
	assign q     = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (room) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (room && load) begin
			data_q <= d;
		end
	end

	`ASSERT_IMPL(a_load_has_room, clk, arst_n, load, room,
		"result loaded while the register is held")
	`ASSERT_IMPL(a_status_code_range, clk, arst_n, valid_q,
		data_q.status <= xcfd_pkg::ST_CHECK, "status code out of range")
	`ASSERT_IMPL(a_payload_status_ok, clk, arst_n,
		valid_q && data_q.kind == xcfd_pkg::KIND_PAYLOAD,
		data_q.status == xcfd_pkg::ST_OK, "payload result carries a status")

endmodule

/* rtl/xor_checked_frame_deframer.sv */
// ----------------------------------------------------------------------------
// xor_checked_frame_deframer
// Byte-serial parser for short frames with an xor checksum.
// ----------------------------------------------------------------------------
// usage:
// wire channel: wire_valid, wire_stall, wire_byte, wire_last; a byte transfers
//   on a rising edge with wire_valid high and wire_stall low. wire_last marks
//   the final byte of a frame.
// result channel: res_valid, res_stall and the result fields; a result
//   transfers on a rising edge with res_valid high and res_stall low.
//   kind 0 is a tentative payload byte, kind 1 the end of frame status.
// config channel: cfg_valid, cfg_ready, cfg_data writes max_payload; write
//   it only while no frame byte is in flight.
// path: a taken byte passes the input register and the decode into the result
//   register (res_valid then high); bytes that cause no result just update state.
// throughput: one byte per cycle while no held result is stalled, set by the
//   input register feeding the single decode stage into the result register.
// reset: frame state clears, max_payload returns to 255, both valids drop.
// stall: a held result keeps the result register; the input register then
//   fills and wire_stall rises until the receiver takes the result.
// ----------------------------------------------------------------------------
module xor_checked_frame_deframer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wire_valid,
	output logic       wire_stall,
	input  logic [7:0] wire_byte,
	input  logic       wire_last,
	output logic       res_valid,
	input  logic       res_stall,
	output logic       kind,
	output logic [7:0] payload_byte,
	output logic [7:0] polling_address,
	output logic [7:0] command,
	output logic [7:0] payload_length,
	output logic [2:0] status,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);

	logic           valid_s1;
	logic [7:0]     byte_s1;
	logic           last_s1;
	logic [7:0]     max_payload_q;
	logic           room;
	logic           adv;
	logic           take;
	logic           fire;
	xcfd_pkg::res_t res;
	xcfd_pkg::res_t res_q;

	assign cfg_ready  = 1'b1;
	assign adv        = valid_s1 && room;
	assign wire_stall = valid_s1 && !room;
	assign take       = wire_valid && !wire_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= xcfd_pkg::MAX_PAYLOAD_RST;
		end else if (cfg_valid && cfg_ready) begin
			max_payload_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= wire_byte;
			last_s1 <= wire_last;
		end
	end

	xcfd_parse u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (adv),
		.byte_in     (byte_s1),
		.last_in     (last_s1),
		.max_payload (max_payload_q),
		.res_fire    (fire),
		.res         (res)
	);

	xcfd_out u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (fire),
		.d      (res),
		.stall  (res_stall),
		.room   (room),
		.valid  (res_valid),
		.q      (res_q)
	);

	assign kind            = res_q.kind;
	assign payload_byte    = res_q.payload_byte;
	assign polling_address = res_q.polling_address;
	assign command         = res_q.command;
	assign payload_length  = res_q.payload_length;
	assign status          = res_q.status;

endmodule

/* dv/xor_checked_frame_deframer_tb.sv */
// ----------------------------------------------------------------------------
// xor_checked_frame_deframer_tb
// Feeds wire frames byte by byte through the deframer and checks every
// payload and status result against a cycle-free model of the frame parser,
// across several max_payload settings, with random gaps on the wire channel
// and random stalls on the result channel.
// ----------------------------------------------------------------------------
module xor_checked_frame_deframer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned PHASE_BYTES   = 130;

	typedef struct {
		logic [7:0]  b;
		logic        last;
		int unsigned gap;
	} link_byte_t;

	typedef enum {
		SHAPE_GOOD,
		SHAPE_BAD_SUM,
		SHAPE_BAD_DELIM,
		SHAPE_OVER,
		SHAPE_BAD_LEN,
		SHAPE_SHORT,
		SHAPE_NOISE,
		SHAPE_LONG
	} frame_shape_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       wire_valid = 1'b0;
	logic       wire_stall;
	logic [7:0] wire_byte = 8'd0;
	logic       wire_last = 1'b0;
	logic       res_valid;
	logic       res_stall = 1'b0;
	logic       kind;
	logic [7:0] payload_byte;
	logic [7:0] polling_address;
	logic [7:0] command;
	logic [7:0] payload_length;
	logic [2:0] status;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_data = 8'd0;

	xor_checked_frame_deframer DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.wire_valid      (wire_valid),
		.wire_stall      (wire_stall),
		.wire_byte       (wire_byte),
		.wire_last       (wire_last),
		.res_valid       (res_valid),
		.res_stall       (res_stall),
		.kind            (kind),
		.payload_byte    (payload_byte),
		.polling_address (polling_address),
		.command         (command),
		.payload_length  (payload_length),
		.status          (status),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// parser model state
	logic [8:0] frame_pos;
	logic [7:0] frame_xor;
	logic [7:0] hdr_addr;
	logic [7:0] hdr_cmd;
	logic [7:0] hdr_count;
	logic       delim_ok;
	logic [7:0] limit_model = xcfd_pkg::MAX_PAYLOAD_RST;

	link_byte_t      link_bytes_pending[$];
	xcfd_pkg::res_t  frame_results_due[$];
	int unsigned     bytes_queued;
	int unsigned     bytes_taken;
	int unsigned     mismatches;
	bit              tx_quiet;
	bit              rx_quiet;

	function automatic void clear_frame_model();
		frame_pos = '0;
		frame_xor = '0;
		hdr_addr  = '0;
		hdr_cmd   = '0;
		hdr_count = '0;
		delim_ok  = 1'b0;
	endfunction

	// advance the parser by one wire byte and queue the result it causes
	function automatic void parse_wire_byte(input logic [7:0] b, input logic last);
		logic [8:0]     p;
		logic [9:0]     total;
		logic [2:0]     st;
		xcfd_pkg::res_t r;
		p = frame_pos;
		if (p == 9'd0) begin
			delim_ok = (b == xcfd_pkg::FRAME_DELIM);
		end else if (p == 9'd1) begin
			hdr_addr = b;
		end else if (p == 9'd2) begin
			hdr_cmd = b;
		end else if (p == 9'd3) begin
			hdr_count = b;
		end
		frame_xor = frame_xor ^ b;
		r.payload_byte    = 8'd0;
		r.polling_address = hdr_addr;
		r.command         = hdr_cmd;
		r.payload_length  = hdr_count;
		if (!last) begin
			if (p < xcfd_pkg::POS_MAX) begin
				frame_pos = p + 9'd1;
			end
			if (delim_ok && hdr_count <= limit_model && p >= 9'd4
					&& {1'b0, p} < xcfd_pkg::HDR_LEN + {2'b00, hdr_count}) begin
				r.kind         = xcfd_pkg::KIND_PAYLOAD;
				r.payload_byte = b;
				r.status       = xcfd_pkg::ST_OK;
				frame_results_due.push_back(r);
			end
		end else begin
			// a saturated position gives a total of 512, which never matches a count
			total = {1'b0, p} + 10'd1;
			if (total < xcfd_pkg::FRAME_OVERHEAD) begin
				st = xcfd_pkg::ST_SHORT;
			end else if (!delim_ok) begin
				st = xcfd_pkg::ST_DELIM;
			end else if (hdr_count > limit_model) begin
				st = xcfd_pkg::ST_OVER;
			end else if (total != {2'b00, hdr_count} + xcfd_pkg::FRAME_OVERHEAD) begin
				st = xcfd_pkg::ST_LENGTH;
			end else if (frame_xor != 8'd0) begin
				st = xcfd_pkg::ST_CHECK;
			end else begin
				st = xcfd_pkg::ST_OK;
			end
			r.kind   = xcfd_pkg::KIND_STATUS;
			r.status = st;
			frame_results_due.push_back(r);
			clear_frame_model();
		end
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("tb: mismatch at %0t ns: %s", $time, what);
	endtask

	task automatic compare_field(input string name, input int got, input int want);
		if (got != want) begin
			report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
		end
	endtask

	task automatic queue_wire_frame(input logic [7:0] fb[$]);
		link_byte_t it;
		foreach (fb[i]) begin
			it.b    = fb[i];
			it.last = (i == fb.size() - 1);
			it.gap  = tx_quiet ? 0 : $urandom_range(0, 5);
			link_bytes_pending.push_back(it);
			bytes_queued++;
		end
	endtask

	task automatic queue_frame(input frame_shape_t shape);
		logic [7:0]  fb[$];
		logic [7:0]  n;
		logic [7:0]  sum;
		logic [7:0]  fill;
		int unsigned body;
		int unsigned cut;
		int unsigned span;
		span = (limit_model < 8'd8) ? limit_model : 8;
		if (limit_model <= 8'd40 && $urandom_range(0, 7) == 0) begin
			n = limit_model;
		end else if ($urandom_range(0, 24) == 0) begin
			n = 8'($urandom_range(0, limit_model));
		end else begin
			n = 8'($urandom_range(0, span));
		end
		if (shape == SHAPE_OVER) begin
			n = 8'($urandom_range(int'(limit_model) + 1, 255));
		end
		fb.push_back(xcfd_pkg::FRAME_DELIM);
		fb.push_back(8'($urandom_range(0, 255)));
		fb.push_back(8'($urandom_range(0, 255)));
		fb.push_back(n);
		// over-limit frames carry at most eight body bytes, the count alone decides them
		body = (shape == SHAPE_OVER) ? $urandom_range(0, (n < 8'd8) ? n : 8) : n;
		repeat (body) fb.push_back(8'($urandom_range(0, 255)));
		sum = 8'd0;
		foreach (fb[i]) sum = sum ^ fb[i];
		fb.push_back(sum);
		case (shape)
			SHAPE_BAD_SUM: begin
				fb[fb.size() - 1] = sum ^ 8'(1 << $urandom_range(0, 7));
			end
			SHAPE_BAD_DELIM: begin
				do fb[0] = 8'($urandom_range(0, 255));
				while (fb[0] == xcfd_pkg::FRAME_DELIM);
			end
			SHAPE_BAD_LEN: begin
				cut = $urandom_range(1, 3);
				if (n >= cut && $urandom_range(0, 1) == 1) begin
					repeat (cut) fb.delete(fb.size() - 2);
				end else begin
					repeat (cut) fb.insert(fb.size() - 1, 8'($urandom_range(0, 255)));
				end
			end
			SHAPE_SHORT: begin
				fb.delete();
				repeat ($urandom_range(1, 4)) fb.push_back(8'($urandom_range(0, 255)));
				if ($urandom_range(0, 1) == 1) begin
					fb[0] = xcfd_pkg::FRAME_DELIM;
				end
			end
			SHAPE_NOISE: begin
				fb.delete();
				repeat ($urandom_range(1, 12)) fb.push_back(8'($urandom_range(0, 255)));
			end
			SHAPE_LONG: begin
				// runs the byte position into saturation
				cut = 512 + $urandom_range(0, 6);
				while (fb.size() < cut) begin
					fill = 8'($urandom_range(0, 255));
					fb.insert(fb.size() - 1, fill);
				end
			end
			default: begin
			end
		endcase
		queue_wire_frame(fb);
	endtask

	task automatic write_max_payload(input logic [7:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		limit_model = value;
	endtask

	task automatic wait_frame_idle();
		do @(negedge clk);
		while (link_bytes_pending.size() != 0 || wire_valid || frame_results_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// sender
	link_byte_t  next_byte;
	int unsigned gap_count;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wire_valid  <= 1'b0;
			gap_count   <= 0;
			bytes_taken <= 0;
		end else begin
			if (wire_valid && !wire_stall) begin
				parse_wire_byte(wire_byte, wire_last);
				bytes_taken <= bytes_taken + 1;
			end
			if (!wire_valid || !wire_stall) begin
				if (link_bytes_pending.size() == 0) begin
					wire_valid <= 1'b0;
				end else if (gap_count < link_bytes_pending[0].gap) begin
					gap_count  <= gap_count + 1;
					wire_valid <= 1'b0;
				end else begin
					next_byte   = link_bytes_pending.pop_front();
					wire_valid <= 1'b1;
					wire_byte  <= next_byte.b;
					wire_last  <= next_byte.last;
					gap_count  <= 0;
				end
			end
		end
	end

	// long receiver hold-off, once on purpose and now and then at random
	int unsigned choke_left;
	bit          choke_done;
	logic        choke_on;

	assign choke_on = (choke_left != 0);

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			choke_left <= 0;
			choke_done <= 1'b0;
		end else if (choke_left != 0) begin
			choke_left <= choke_left - 1;
		end else if ((!choke_done && bytes_taken >= 300) || $urandom_range(0, 799) == 0) begin
			choke_left <= $urandom_range(40, 90);
			choke_done <= 1'b1;
		end
	end

	// receiver
	xcfd_pkg::res_t want;
	int unsigned    stall_left;
	int unsigned    wait_draw;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall  <= 1'b0;
			stall_left <= 0;
		end else if (res_valid && !res_stall) begin
			if (frame_results_due.size() == 0) begin
				report_mismatch("result transfer with nothing expected");
			end else begin
				want = frame_results_due.pop_front();
				compare_field("kind", kind, want.kind);
				compare_field("payload_byte", payload_byte, want.payload_byte);
				compare_field("polling_address", polling_address, want.polling_address);
				compare_field("command", command, want.command);
				compare_field("payload_length", payload_length, want.payload_length);
				compare_field("status", status, want.status);
			end
			wait_draw   = rx_quiet ? 0 : $urandom_range(0, 5);
			stall_left <= wait_draw;
			res_stall  <= choke_on || wait_draw != 0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			res_stall  <= choke_on || stall_left > 1;
		end else begin
			res_stall <= choke_on;
		end
	end

	initial begin
		int unsigned target;
		int unsigned roll;
		logic [7:0]  lim;
		logic [7:0]  fb[$];
		clear_frame_model();
		bytes_queued = 0;
		mismatches   = 0;
		tx_quiet     = 1'b0;
		rx_quiet     = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// extremes of the header, each status reachable at the reset limit,
		// and a payload frame whose count ends on the last byte
		fb = '{xcfd_pkg::FRAME_DELIM, 8'hFF, 8'hFF, 8'h00, 8'h02};
		queue_wire_frame(fb);
		fb = '{8'hFF};
		queue_wire_frame(fb);
		fb = '{8'h00, 8'h12, 8'h34, 8'h00, 8'h26};
		queue_wire_frame(fb);
		fb = '{xcfd_pkg::FRAME_DELIM, 8'h01, 8'h02, 8'h01, 8'h00};
		queue_wire_frame(fb);
		fb = '{xcfd_pkg::FRAME_DELIM, 8'h80, 8'h7F, 8'h01, 8'hFF, 8'h13};
		queue_wire_frame(fb);
		wait_frame_idle();

		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: lim = 8'd0;
				1: lim = 8'd255;
				2: lim = 8'($urandom_range(1, 6));
				3: lim = 8'($urandom_range(0, 255));
				4: lim = 8'd1;
				5: lim = 8'($urandom_range(7, 40));
				default: lim = 8'd255;
			endcase
			write_max_payload(lim);
			@(negedge clk);
			tx_quiet = (ph == 3 || ph == 5);
			rx_quiet = (ph == 3 || ph == 1);
			target   = bytes_queued + PHASE_BYTES;
			while (bytes_queued < target) begin
				roll = $urandom_range(0, 99);
				if (roll < 45) begin
					queue_frame(SHAPE_GOOD);
				end else if (roll < 55) begin
					queue_frame(SHAPE_BAD_SUM);
				end else if (roll < 65) begin
					queue_frame(SHAPE_BAD_DELIM);
				end else if (roll < 75) begin
					queue_frame((limit_model == 8'd255) ? SHAPE_GOOD : SHAPE_OVER);
				end else if (roll < 85) begin
					queue_frame(SHAPE_BAD_LEN);
				end else if (roll < 93) begin
					queue_frame(SHAPE_SHORT);
				end else begin
					queue_frame(SHAPE_NOISE);
				end
			end
			if (ph == 6) begin
				queue_frame(SHAPE_LONG);
			end
			// stimulus waits until every queued byte is sent and every expected result is back
			wait_frame_idle();
		end

		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule

/* xor_checked_frame_deframer.f */
+incdir+rtl
rtl/xcfd_pkg.sv
rtl/xcfd_parse.sv
rtl/xcfd_out.sv
rtl/xor_checked_frame_deframer.sv
dv/xor_checked_frame_deframer_tb.sv
